@@ design/imu_complementary_tilt_filter_defines.svh @@
// Assertion macros for the tilt filter checker
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
// implication checked every clock, quiet during reset
`define ICTF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ICTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/ictf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ictf_pkg
// Shared types, constants and the CORDIC arctangent table for the tilt filter.
// ---------------------------------------------------------------------------
package ictf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE = 1'b1;

    localparam logic [15:0] BLEND_GAIN_RST = 16'd64225;
    localparam logic [23:0] GYRO_SCALE_RST = 24'd128074;

    localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] OUT_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [15:0]        time_step;
    } in_req_t;

    typedef struct packed {
        logic signed [23:0] tilt_from_y;
        logic signed [23:0] tilt_from_x;
        logic signed [23:0] spin_about_z;
    } out_req_t;

    // lane control from the top level
    typedef struct packed {
        logic start;
        logic step;
    } lane_ctl_t;

    // atan(2^-i) in Q.16 degrees
    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:  v = 22'd2949120;
                5'd1:  v = 22'd1740967;
                5'd2:  v = 22'd919879;
                5'd3:  v = 22'd466945;
                5'd4:  v = 22'd234379;
                5'd5:  v = 22'd117304;
                5'd6:  v = 22'd58666;
                5'd7:  v = 22'd29335;
                5'd8:  v = 22'd14668;
                5'd9:  v = 22'd7334;
                5'd10: v = 22'd3667;
                5'd11: v = 22'd1833;
                5'd12: v = 22'd917;
                5'd13: v = 22'd458;
                5'd14: v = 22'd229;
                5'd15: v = 22'd115;
                5'd16: v = 22'd57;
                5'd17: v = 22'd29;
                5'd18: v = 22'd14;
                5'd19: v = 22'd7;
                5'd20: v = 22'd4;
                5'd21: v = 22'd2;
                5'd22: v = 22'd1;
                default: v = 22'd0;
            endcase
            atan_q16 = v;
        end
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        begin
            if (v > 48'(OUT_MAX))
                sat24 = OUT_MAX;
            else if (v < 48'(OUT_MIN))
                sat24 = OUT_MIN;
            else
                sat24 = v[23:0];
        end
    endfunction

endpackage

@@ design/ictf_tilt_lane.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ictf_tilt_lane
// One accelerometer tilt lane: bit-serial integer square root of
// (b^2+c^2)<<16 (one result bit per step), then a vectoring CORDIC,
// one iteration per step. Result is atan2(a, r) in Q.16 degrees.
// ---------------------------------------------------------------------------
module ictf_tilt_lane #(
    parameter int CordicSteps = ictf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ictf_pkg::lane_ctl_t       ctl,
    input  logic signed [15:0]        a,
    input  logic signed [15:0]        b,
    input  logic signed [15:0]        c,
    output logic                      done,
    output logic signed [23:0]        angle
);
    localparam int NSTEP = (CordicSteps > ictf_pkg::ATAN_LEN) ? ictf_pkg::ATAN_LEN
                                                                : CordicSteps;
    // operand of sqrt is < 2^48: 24 result bits
    localparam int SQ_BITS = 24;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SQRT = 2'd1;
    localparam logic [1:0] PH_ROT  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]         ph_reg, ph_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [47:0]        rad_reg, rad_next;     // remaining operand bits
    logic [25:0]        rem_reg, rem_next;     // partial remainder
    logic [23:0]        root_reg, root_next;
    logic signed [27:0] x_reg, x_next;
    logic signed [27:0] y_reg, y_next;
    logic signed [23:0] z_reg, z_next;
    logic               zero_reg, zero_next;

    logic [32:0] sq;
    logic [25:0] trial_rem;
    logic [25:0] trial_sub;
    logic signed [27:0] xs, ys;
    logic signed [23:0] at;

    always_comb
    begin
        sq = 33'($signed(b) * $signed(b)) + 33'($signed(c) * $signed(c));
        // restoring sqrt: bring down two bits, try 4*root+1
        trial_rem = {rem_reg[23:0], rad_reg[47:46]};
        trial_sub = {root_reg, 2'b01};
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = 24'(ictf_pkg::atan_q16(cnt_reg));

        ph_next   = ph_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;

        unique case (ph_reg)
            PH_IDLE:
            begin
                if (ctl.start)
                begin
                    ph_next   = PH_SQRT;
                    cnt_next  = '0;
                    rad_next  = {sq[31:0], 16'd0};
                    rem_next  = '0;
                    root_next = '0;
                    zero_next = (a == 16'sd0);
                    y_next    = 28'(a) <<< 8;
                    z_next    = '0;
                end
            end
            PH_SQRT:
            begin
                rad_next = {rad_reg[45:0], 2'b00};
                if (trial_rem >= trial_sub)
                begin
                    rem_next  = trial_rem - trial_sub;
                    root_next = {root_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial_rem;
                    root_next = {root_reg[22:0], 1'b0};
                end
                if (cnt_reg == 5'(SQ_BITS - 1))
                begin
                    ph_next  = (NSTEP == 0) ? PH_DONE : PH_ROT;
                    cnt_next = '0;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            PH_ROT:
            begin
                if (cnt_reg == '0)
                begin
                    // first rotation uses the fresh root
                    if (!y_reg[27])
                    begin
                        x_next = 28'({4'd0, root_reg}) + y_reg;
                        y_next = y_reg - 28'({4'd0, root_reg});
                        z_next = z_reg + at;
                    end
                    else
                    begin
                        x_next = 28'({4'd0, root_reg}) - y_reg;
                        y_next = y_reg + 28'({4'd0, root_reg});
                        z_next = z_reg - at;
                    end
                end
                else if (!y_reg[27])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                if (cnt_reg == 5'(NSTEP - 1))
                    ph_next = PH_DONE;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            PH_DONE:
            begin
                if (ctl.step)
                    ph_next = PH_IDLE;
            end
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            ph_reg  <= ph_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign done  = (ph_reg == PH_DONE);
    assign angle = zero_reg ? 24'sd0 : z_reg;

endmodule

@@ design/ictf_merge.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ictf_merge
// Merging stage: gyro deltas and the blend of both tilt lanes with the
// previous angles, plus Z integration. A small sequencer steps the axes
// through the multipliers: products are registered between steps.
// ---------------------------------------------------------------------------
module ictf_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   hold,
    input  ictf_pkg::in_req_t      req,
    input  logic [15:0]            beta,
    input  logic [23:0]            scale,
    input  logic signed [23:0]     acc_x,
    input  logic signed [23:0]     acc_y,
    input  logic                   lanes_done,
    output logic                   done,
    output ictf_pkg::out_req_t     res
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GS   = 4'd1;  // gyro * scale per axis (3 steps)
    localparam logic [3:0] S_GD   = 4'd2;  // * dt per axis (3 steps)
    localparam logic [3:0] S_WAIT = 4'd3;
    localparam logic [3:0] S_BL   = 4'd4;  // blend products
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;

    logic [3:0]         st_reg, st_next;
    logic [1:0]         ax_reg, ax_next;
    logic signed [40:0] gs_reg [3];        // gyro*scale
    logic signed [40:0] dl_reg [3];        // delta Q.24
    logic signed [23:0] prev_reg [3];      // y, x, z
    logic signed [49:0] bl_reg [2];        // blended sums
    ictf_pkg::out_req_t res_reg;

    logic signed [15:0] g_sel;
    logic signed [40:0] gs_val;
    logic signed [57:0] p;
    logic signed [40:0] d_val;
    logic signed [40:0] pred;
    logic signed [23:0] acc_sel;
    logic signed [49:0] s_val;
    logic signed [40:0] spin_s;

    always_comb
    begin
        case (ax_reg)
            2'd0:    g_sel = req.gyro_y;
            2'd1:    g_sel = req.gyro_x;
            default: g_sel = req.gyro_z;
        endcase
        gs_val = 41'(g_sel) * $signed({1'b0, scale});
        p      = 58'(gs_reg[ax_reg]) * $signed({1'b0, req.time_step});
        d_val  = 41'((p + 58'sd8388608) >>> 24);
        pred   = (41'(prev_reg[ax_reg]) <<< 8) + dl_reg[ax_reg];
        acc_sel = (ax_reg == 2'd0) ? acc_y : acc_x;
        // pred*beta reaches 2^48: sum kept at 50 bits
        s_val  = 50'(acc_sel) * $signed({1'b0, 17'(18'd65536 - 18'(beta))})
               + 50'(pred) * $signed({1'b0, beta});
        spin_s = ((41'(prev_reg[2]) <<< 8) + dl_reg[2] + 41'sd128) >>> 8;
    end

    always_comb
    begin
        st_next = st_reg;
        ax_next = ax_reg;
        unique case (st_reg)
            S_IDLE: if (start) begin st_next = S_GS; ax_next = 2'd0; end
            S_GS:
            begin
                if (ax_reg == 2'd2) begin st_next = S_GD; ax_next = 2'd0; end
                else ax_next = ax_reg + 2'd1;
            end
            S_GD:
            begin
                if (ax_reg == 2'd2) begin st_next = S_WAIT; ax_next = 2'd0; end
                else ax_next = ax_reg + 2'd1;
            end
            S_WAIT: if (lanes_done) st_next = S_BL;
            S_BL:
            begin
                if (ax_reg == 2'd1) st_next = S_FIN;
                else ax_next = ax_reg + 2'd1;
            end
            S_FIN:   st_next = S_OUT;
            // result stays offered while the output register is full and stalled
            S_OUT:   if (!hold) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            ax_reg      <= '0;
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
            prev_reg[2] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ax_reg <= ax_next;
            if (st_reg == S_FIN)
            begin
                prev_reg[0] <= ictf_pkg::sat24(48'(bl_reg[0] >>> 24));
                prev_reg[1] <= ictf_pkg::sat24(48'(bl_reg[1] >>> 24));
                prev_reg[2] <= ictf_pkg::sat24(48'(spin_s));
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (st_reg == S_GS)
            gs_reg[ax_reg] <= gs_val;
        if (st_reg == S_GD)
            dl_reg[ax_reg] <= d_val;
        if (st_reg == S_BL)
            bl_reg[ax_reg[0]] <= s_val + 50'sd8388608;
        if (st_reg == S_FIN)
        begin
            res_reg.tilt_from_y  <= ictf_pkg::sat24(48'(bl_reg[0] >>> 24));
            res_reg.tilt_from_x  <= ictf_pkg::sat24(48'(bl_reg[1] >>> 24));
            res_reg.spin_about_z <= ictf_pkg::sat24(48'(spin_s));
        end
    end

    assign done = (st_reg == S_OUT);
    assign res  = res_reg;

endmodule

@@ design/imu_complementary_tilt_filter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary tilt filter: two accelerometer tilt lanes (sqrt + CORDIC)
// run side by side, a merging stage blends them with the gyro integration.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | ictf_pkg::in_req_t
//  out     | output    | out_valid / out_stall| ictf_pkg::out_req_t
//  cfg     | input     | cfg_we               | cfg_idx, cfg_data
//
// A result passes through the lanes' square-root bits and CORDIC
// iterations, then the merge blend, before it lands in the output register.
// The next request is taken once that result is in the output register.
// Reset clears the angle state and loads the register defaults.
// The result is held in an output register; a new request is taken while
// it waits, and its result waits until the previous one is taken.
// ---------------------------------------------------------------------------
module imu_complementary_tilt_filter #(
    parameter int CordicSteps = ictf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ictf_pkg::in_req_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ictf_pkg::out_req_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [ictf_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [ictf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    logic [15:0]        beta_reg;
    logic [23:0]        scale_reg;
    logic               busy_reg;
    logic               ov_reg;
    ictf_pkg::in_req_t  req_reg;
    ictf_pkg::out_req_t od_reg;
    ictf_pkg::lane_ctl_t ctl;
    logic               accept, dx, dy, mdone;
    logic signed [23:0] ang_x, ang_y;
    ictf_pkg::out_req_t mres;
    logic               mstart_reg;

    // one request in flight; the output register frees the input side
    assign accept   = in_valid && !in_stall;
    assign in_stall = busy_reg;

    assign ctl.start = accept;
    assign ctl.step  = mdone;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg  <= ictf_pkg::BLEND_GAIN_RST;
            scale_reg <= ictf_pkg::GYRO_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                ictf_pkg::REG_BLEND_GAIN: beta_reg  <= cfg_data[15:0];
                ictf_pkg::REG_GYRO_SCALE: scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control: busy until result lands in the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            mstart_reg <= 1'b0;
        end
        else
        begin
            mstart_reg <= accept;
            if (accept)
                busy_reg <= 1'b1;
            else if (mdone && !(ov_reg && out_stall))
                busy_reg <= 1'b0;
            if (mdone && !(ov_reg && out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_data;
        if (mdone && !(ov_reg && out_stall))
            od_reg <= mres;
    end

    ictf_tilt_lane #(.CordicSteps(CordicSteps)) u_lane_x (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .a(in_data.accel_x), .b(in_data.accel_y), .c(in_data.accel_z),
        .done(dx), .angle(ang_x)
    );

    ictf_tilt_lane #(.CordicSteps(CordicSteps)) u_lane_y (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .a(in_data.accel_y), .b(in_data.accel_x), .c(in_data.accel_z),
        .done(dy), .angle(ang_y)
    );

    // merge holds S_OUT until the output register can take it
    ictf_merge u_merge (
        .clk(clk), .rst_n(rst_n), .start(mstart_reg), .hold(ov_reg && out_stall),
        .req(req_reg), .beta(beta_reg), .scale(scale_reg), .acc_x(ang_x), .acc_y(ang_y),
        .lanes_done(dx && dy), .done(mdone), .res(mres)
    );

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

@@ design/ictf_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ictf_checker
// Port-level checks for the tilt filter.
// ---------------------------------------------------------------------------
`include "imu_complementary_tilt_filter_defines.svh"

module ictf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input ictf_pkg::out_req_t out_data
);
    // held result stays put
    `ICTF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable(out_data))
    // an accepted request makes the block busy next cycle
    `ICTF_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
    // a fresh result never shows the cycle after a request
    `ICTF_ASSERT_NEXT(a_no_instant, in_valid && !in_stall && !out_valid, !out_valid)
endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
